// File: src/pii_pkg.sv
`default_nettype none

package pii_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int MAX_HEIGHT_DEFAULT = 256;

   // Fixed field widths
   localparam int PIXEL_BITS  = 8;
   localparam int COORD_W     = 9;
   localparam int CFG_DIM_W   = 9;
   localparam int CFG_PAD_W   = 7;
   localparam int SUM_W       = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   // Request stream packing
   localparam int REQ_TDATA_W    = 32;
   localparam int REQ_TUSER_W    = 2;
   localparam int PIXEL_LSB      = 0;
   localparam int PAD_X_LSB      = PIXEL_LSB + PIXEL_BITS;
   localparam int PAD_Y_LSB      = PAD_X_LSB + COORD_W;
   localparam int TUSER_TYPE_BIT  = 0;
   localparam int TUSER_START_BIT = 1;

   localparam int QUEUE_DEPTH = 4;

   // Register reset values
   localparam logic [CFG_DIM_W-1:0] IMG_WIDTH_RESET  = 9'd256;
   localparam logic [CFG_DIM_W-1:0] IMG_HEIGHT_RESET = 9'd256;
   localparam logic [CFG_PAD_W-1:0] PAD_BORDER_RESET = 7'd0;

   // Request kinds carried in tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMG_WIDTH  = 2'd0,
      REG_IMG_HEIGHT = 2'd1,
      REG_PAD_BORDER = 2'd2
   } reg_index_type;

   // Work classified by the front end
   typedef enum logic [1:0] {
      OP_LOAD_TOP = 2'd0,   // load on the first row, nothing above
      OP_LOAD     = 2'd1,   // load that adds the entry above
      OP_READ     = 2'd2,   // read one store entry
      OP_ZERO     = 2'd3    // read inside the top or left border
   } op_type;

   localparam int OP_W = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_EXEC = 2'b10
   } back_state_type;

endpackage

`default_nettype wire

// File: src/pii_front.sv
`default_nettype none

module pii_front #(
   parameter int MAX_WIDTH  = pii_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = pii_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   input  wire logic [pii_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pii_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [pii_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [pii_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  wire pii_pkg::queue_status_type          q_status,
   output logic                                    q_push,
   output pii_pkg::op_type                         q_op,
   output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] q_addr,
   output logic [$clog2(MAX_WIDTH*((1<<pii_pkg::PIXEL_BITS)-1)+1)-1:0] q_row_sum
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int RS_W  = $clog2(MAX_WIDTH*((1<<pii_pkg::PIXEL_BITS)-1)+1);
   localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DW    = ($clog2(MAXD+1) > pii_pkg::CFG_DIM_W) ?
                          $clog2(MAXD+1) : pii_pkg::CFG_DIM_W;

   logic [pii_pkg::CFG_DIM_W-1:0] width_ff, height_ff;
   logic [pii_pkg::CFG_PAD_W-1:0] pad_ff;
   logic [COL_W-1:0]              col_ff, col_in, col_c;
   logic [ROW_W-1:0]              row_ff, row_in, row_c;
   logic [RS_W-1:0]               rs_ff, rs_in, rs_c, rs_sum;
   logic [DW-1:0]                 eff_w, eff_h, col_next, row_next;
   logic [DW-1:0]                 ix_c, iy_c;
   logic [pii_pkg::COORD_W-1:0]   pad_x, pad_y, pad_ext, ix, iy;
   logic [pii_pkg::PIXEL_BITS-1:0] pixel;
   logic                          accept, is_load, frame_start, in_border;

   assign pixel       = req_tdata[pii_pkg::PIXEL_LSB +: pii_pkg::PIXEL_BITS];
   assign pad_x       = req_tdata[pii_pkg::PAD_X_LSB +: pii_pkg::COORD_W];
   assign pad_y       = req_tdata[pii_pkg::PAD_Y_LSB +: pii_pkg::COORD_W];
   assign is_load     = (req_tuser[pii_pkg::TUSER_TYPE_BIT] == pii_pkg::REQ_LOAD);
   assign frame_start = req_tuser[pii_pkg::TUSER_START_BIT];

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pii_pkg::IMG_WIDTH_RESET;
         height_ff <= pii_pkg::IMG_HEIGHT_RESET;
         pad_ff    <= pii_pkg::PAD_BORDER_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pii_pkg::REG_IMG_WIDTH:  width_ff  <= csr_data;
            pii_pkg::REG_IMG_HEIGHT: height_ff <= csr_data;
            pii_pkg::REG_PAD_BORDER: pad_ff    <= csr_data[pii_pkg::CFG_PAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the programmed size to 1..MAX
   always_comb begin
      if (width_ff == '0)
         eff_w = DW'(1);
      else if (DW'(width_ff) > DW'(MAX_WIDTH))
         eff_w = DW'(MAX_WIDTH);
      else
         eff_w = DW'(width_ff);
      if (height_ff == '0)
         eff_h = DW'(1);
      else if (DW'(height_ff) > DW'(MAX_HEIGHT))
         eff_h = DW'(MAX_HEIGHT);
      else
         eff_h = DW'(height_ff);
   end

   // Raster position of a load
   always_comb begin
      col_c = col_ff;
      row_c = row_ff;
      rs_c  = rs_ff;
      if (frame_start || DW'(col_ff) >= eff_w || DW'(row_ff) >= eff_h) begin
         col_c = '0;
         row_c = '0;
         rs_c  = '0;
      end
      rs_sum   = rs_c + RS_W'(pixel);
      col_next = DW'(col_c) + DW'(1);
      row_next = DW'(row_c) + DW'(1);
      if (col_next >= eff_w) begin
         col_in = '0;
         rs_in  = '0;
         row_in = (row_next >= eff_h) ? '0 : row_next[ROW_W-1:0];
      end else begin
         col_in = col_next[COL_W-1:0];
         rs_in  = rs_sum;
         row_in = row_c;
      end
   end

   // Padded read: border test, shift and clamp
   always_comb begin
      pad_ext   = pii_pkg::COORD_W'(pad_ff);
      in_border = (pad_x < pad_ext) || (pad_y < pad_ext);
      ix        = pad_x - pad_ext;
      iy        = pad_y - pad_ext;
      ix_c      = (DW'(ix) > eff_w - DW'(1)) ? eff_w - DW'(1) : DW'(ix);
      iy_c      = (DW'(iy) > eff_h - DW'(1)) ? eff_h - DW'(1) : DW'(iy);
   end

   always_comb begin
      if (is_load) begin
         q_op      = (row_c != '0) ? pii_pkg::OP_LOAD : pii_pkg::OP_LOAD_TOP;
         q_addr    = {row_c, col_c};
         q_row_sum = rs_sum;
      end else begin
         q_op      = in_border ? pii_pkg::OP_ZERO : pii_pkg::OP_READ;
         q_addr    = {iy_c[ROW_W-1:0], ix_c[COL_W-1:0]};
         q_row_sum = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         rs_ff  <= '0;
      end else if (accept && is_load) begin
         col_ff <= col_in;
         row_ff <= row_in;
         rs_ff  <= rs_in;
      end
   end

endmodule

`default_nettype wire

// File: src/pii_queue.sv
`default_nettype none

module pii_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pii_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [WIDTH-1:0]     push_data,
   input  wire logic                 pop,
   output logic [WIDTH-1:0]          head_data,
   output pii_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// File: src/pii_back.sv
`default_nettype none

module pii_back #(
   parameter int MAX_WIDTH  = pii_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = pii_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pii_pkg::queue_status_type q_status,
   output logic                           q_pop,
   input  wire pii_pkg::op_type           q_op,
   input  wire logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] q_addr,
   input  wire logic [$clog2(MAX_WIDTH*((1<<pii_pkg::PIXEL_BITS)-1)+1)-1:0] q_row_sum,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [pii_pkg::SUM_W-1:0]      rsp_tdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int RS_W   = $clog2(MAX_WIDTH*((1<<pii_pkg::PIXEL_BITS)-1)+1);
   localparam int SUM_W  = pii_pkg::SUM_W;

   logic [SUM_W-1:0]        mem [2**ADDR_W];
   logic [SUM_W-1:0]        rdata_ff;
   pii_pkg::back_state_type st_ff, st_in;
   pii_pkg::op_type         op_ff;
   logic [ADDR_W-1:0]       addr_ff, raddr;
   logic [RS_W-1:0]         rs_ff;
   logic                    mem_re, mem_we;
   logic [SUM_W:0]          sum_wide;
   logic [SUM_W-1:0]        above, wdata;
   logic                    rsp_valid_ff, rsp_valid_in, rsp_free, rsp_load;
   logic [SUM_W-1:0]        rsp_data_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Loads fetch the entry one row up at the same column
   assign raddr = (q_op == pii_pkg::OP_LOAD) ?
                  {q_addr[ADDR_W-1:COL_W] - ROW_W'(1), q_addr[COL_W-1:0]} : q_addr;

   assign above    = (op_ff == pii_pkg::OP_LOAD) ? rdata_ff : '0;
   assign sum_wide = {1'b0, above} + (SUM_W+1)'(rs_ff);
   assign wdata    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   always_comb begin
      st_in    = st_ff;
      q_pop    = 1'b0;
      mem_re   = 1'b0;
      mem_we   = 1'b0;
      rsp_load = 1'b0;
      case (st_ff)
         pii_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop  = 1'b1;
               mem_re = q_op inside {pii_pkg::OP_LOAD, pii_pkg::OP_READ};
               st_in  = pii_pkg::BK_EXEC;
            end
         end
         pii_pkg::BK_EXEC: begin
            if (op_ff inside {pii_pkg::OP_LOAD, pii_pkg::OP_LOAD_TOP}) begin
               mem_we = 1'b1;
               st_in  = pii_pkg::BK_IDLE;
            end else if (rsp_free) begin
               rsp_load = 1'b1;
               st_in    = pii_pkg::BK_IDLE;
            end
         end
         default: st_in = pii_pkg::BK_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= pii_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff   <= q_op;
         addr_ff <= q_addr;
         rs_ff   <= q_row_sum;
      end
      if (rsp_load)
         rsp_data_ff <= (op_ff == pii_pkg::OP_ZERO) ? '0 : rdata_ff;
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we)
         mem[addr_ff] <= wdata;
      if (mem_re)
         rdata_ff <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: src/padded_integral_image_core.sv
`default_nettype none

// Summed-area table builder with padded read-back. Load transactions
// (tuser bit 0 low) deliver gray pixels in raster order; each one adds the
// pixel to the running row sum, adds the table entry one row up and stores
// the result in the frame store. tuser bit 1 on a load restarts the raster
// at row 0, column 0. Read transactions (tuser bit 0 high) return one
// 24-bit table value for a padded coordinate: zero inside the top or left
// border, the clamped last column or row value beyond the right or bottom.
// The front end accepts one transaction per cycle into a four-entry queue
// while the queue is not full. The back end handles each transaction as a
// registered read of the frame store, then the write or the result, and
// starts the next transaction only after finishing the one before. A read
// also waits while the response register is held by the receiver.
// A load produces no response. The frame store is not cleared after reset:
// reading an entry never loaded gives an undefined value. Write the size
// and border registers only while no transaction is in flight.
module padded_integral_image_core #(
   parameter int MAX_WIDTH  = pii_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = pii_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [7:0] pixel, [16:8] pad_x, [25:17] pad_y, [31:26] zero
   input  wire logic [pii_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] req_type, [1] frame_start
   input  wire logic [pii_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [23:0] sum_value
   output logic [pii_pkg::SUM_W-1:0]            rsp_tdata,
   // register write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pii_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pii_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int RS_W   = $clog2(MAX_WIDTH*((1<<pii_pkg::PIXEL_BITS)-1)+1);
   localparam int QW     = pii_pkg::OP_W + ADDR_W + RS_W;

   pii_pkg::queue_status_type q_status;
   pii_pkg::op_type           f_op, b_op;
   logic [ADDR_W-1:0]         f_addr, b_addr;
   logic [RS_W-1:0]           f_row_sum, b_row_sum;
   logic [QW-1:0]             push_word, head_word;
   logic                      q_push, q_pop;

   // Registers are always writable
   assign csr_ready = 1'b1;

   // Front end: hold the registers and raster position, classify each transaction
   pii_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_op       (f_op),
      .q_addr     (f_addr),
      .q_row_sum  (f_row_sum)
   );

   // Pack the classified work into one queue word
   assign push_word = {f_op, f_addr, f_row_sum};
   assign b_op      = pii_pkg::op_type'(head_word[QW-1 -: pii_pkg::OP_W]);
   assign b_addr    = head_word[RS_W +: ADDR_W];
   assign b_row_sum = head_word[RS_W-1:0];

   pii_queue #(
      .WIDTH (QW),
      .DEPTH (pii_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_word),
      .pop       (q_pop),
      .head_data (head_word),
      .status    (q_status)
   );

   // Back end: frame store access and response register
   pii_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .q_op       (b_op),
      .q_addr     (b_addr),
      .q_row_sum  (b_row_sum),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: src/pii_checker.sv
`default_nettype none

module pii_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [pii_pkg::SUM_W-1:0]  rsp_tdata
);

   // No stale response survives reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // The queue comes out of reset empty and takes a request at once
   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request side not ready after reset");

   // A stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response dropped or changed");

endmodule

bind padded_integral_image_core pii_checker u_pii_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: test/padded_integral_image_core_tb.sv
`timescale 1ns / 100ps

module padded_integral_image_core_tb;

   localparam int STORE_W      = pii_pkg::MAX_WIDTH_DEFAULT;
   localparam int STORE_H      = pii_pkg::MAX_HEIGHT_DEFAULT;
   localparam int IDLE_PCT     = 29;
   localparam int READ_PCT     = 35;
   localparam int RANDOM_ITEMS = 1600;
   localparam int QUIET_CYCLES = 16;     // room for five transactions in flight, margin
   localparam int HOLD_CYCLES  = 400;    // one long receiver hold-off
   localparam int STALL_LIMIT  = 2000;   // cycles without any transaction before giving up
   localparam int PLAN_ROWS    = 27;
   localparam int unsigned SUM_LIMIT = 32'h00FF_FFFF;

   typedef enum logic [1:0] {
      STEP_CONFIG,
      STEP_LOAD,
      STEP_READ
   } step_kind_type;

   // One directed row: a register write, a load or a read. arg_a holds the
   // register data, the pixel or pad_x; arg_b holds pad_y.
   typedef struct packed {
      step_kind_type          kind;
      pii_pkg::reg_index_type reg_sel;
      logic                   start;
      logic [8:0]             arg_a;
      logic [8:0]             arg_b;
      logic                   has_sum;
      logic [23:0]            sum;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pii_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [pii_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pii_pkg::SUM_W-1:0]       rsp_tdata;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [pii_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [pii_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   padded_integral_image_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: registers, raster position, row sum and frame store.
   logic [pii_pkg::CFG_DIM_W-1:0] cfg_width  = pii_pkg::IMG_WIDTH_RESET;
   logic [pii_pkg::CFG_DIM_W-1:0] cfg_height = pii_pkg::IMG_HEIGHT_RESET;
   logic [pii_pkg::CFG_PAD_W-1:0] cfg_pad    = pii_pkg::PAD_BORDER_RESET;
   int unsigned row_sum_now = 0;
   int unsigned next_col    = 0;
   int unsigned next_row    = 0;
   int unsigned last_col    = 0;
   int unsigned last_row    = 0;
   int unsigned sat_table [STORE_W*STORE_H];
   bit          written_map [STORE_W*STORE_H];

   logic [pii_pkg::SUM_W-1:0] sum_expect_q [$];
   int  mismatch_count = 0;
   int  stall_cycles   = 0;
   bit  calm           = 1'b0;   // no idling on either side while set
   bit  hold_off_go    = 1'b0;
   bit  hold_off_done  = 1'b0;

   // Size registers: zero behaves as one, anything above the store as the store size.
   function automatic int unsigned clip_dim(logic [pii_pkg::CFG_DIM_W-1:0] v,
                                            int unsigned limit);
      if (v == 0) return 1;
      if (32'(v) > limit) return limit;
      return 32'(v);
   endfunction

   function automatic void predict_table_load(logic [pii_pkg::PIXEL_BITS-1:0] pixel,
                                              logic start);
      int unsigned w, h, above, val;
      w = clip_dim(cfg_width, STORE_W);
      h = clip_dim(cfg_height, STORE_H);
      if (start || next_col >= w || next_row >= h) begin
         next_col    = 0;
         next_row    = 0;
         row_sum_now = 0;
      end
      row_sum_now = row_sum_now + 32'(pixel);
      if (row_sum_now > SUM_LIMIT) row_sum_now = SUM_LIMIT;
      above = (next_row > 0) ? sat_table[(next_row - 1) * STORE_W + next_col] : 0;
      val = row_sum_now + above;
      if (val > SUM_LIMIT) val = SUM_LIMIT;
      sat_table[next_row * STORE_W + next_col]   = val;
      written_map[next_row * STORE_W + next_col] = 1'b1;
      last_col = next_col;
      last_row = next_row;
      // advance the raster, wrapping at the end of the row and of the frame
      next_col++;
      if (next_col >= w) begin
         next_col    = 0;
         row_sum_now = 0;
         next_row++;
         if (next_row >= h) next_row = 0;
      end
   endfunction

   function automatic logic [pii_pkg::SUM_W-1:0] predict_padded_sum(
         logic [pii_pkg::COORD_W-1:0] px, logic [pii_pkg::COORD_W-1:0] py);
      int unsigned w, h, ix, iy;
      w = clip_dim(cfg_width, STORE_W);
      h = clip_dim(cfg_height, STORE_H);
      if (32'(px) < 32'(cfg_pad) || 32'(py) < 32'(cfg_pad)) return '0;
      ix = 32'(px) - 32'(cfg_pad);
      iy = 32'(py) - 32'(cfg_pad);
      if (ix > w - 1) ix = w - 1;
      if (iy > h - 1) iy = h - 1;
      return sat_table[iy * STORE_W + ix][pii_pkg::SUM_W-1:0];
   endfunction

   // Pick a padded coordinate whose store entry has been loaded: mostly near
   // the padded image, sometimes anywhere. Fall back to the last loaded pixel.
   function automatic void pick_read_coords(output logic [pii_pkg::COORD_W-1:0] px,
                                            output logic [pii_pkg::COORD_W-1:0] py);
      int unsigned w, h, ix, iy, lo, pad;
      int tries;
      bit ok;
      w   = clip_dim(cfg_width, STORE_W);
      h   = clip_dim(cfg_height, STORE_H);
      pad = 32'(cfg_pad);
      lo  = (pad > 2) ? pad - 2 : 0;
      ok  = 1'b0;
      px  = '0;
      py  = '0;
      for (tries = 0; tries < 24 && !ok; tries++) begin
         if ($urandom_range(0, 99) < 15) begin
            px = 9'($urandom_range(0, 511));
            py = 9'($urandom_range(0, 511));
         end else begin
            px = 9'($urandom_range(lo, pad + w + 1));
            py = 9'($urandom_range(lo, pad + h + 1));
         end
         if (32'(px) < pad || 32'(py) < pad) begin
            ok = 1'b1;
         end else begin
            ix = 32'(px) - pad;
            iy = 32'(py) - pad;
            if (ix > w - 1) ix = w - 1;
            if (iy > h - 1) iy = h - 1;
            ok = written_map[iy * STORE_W + ix];
         end
      end
      if (!ok) begin
         px = 9'(pad + last_col);
         py = 9'(pad + last_row);
      end
   endfunction

   // Offer one request transaction, with random gaps in front, and return at
   // the rising edge that accepts it.
   task automatic send_request(input logic [pii_pkg::REQ_TUSER_W-1:0] user,
                               input logic [pii_pkg::REQ_TDATA_W-1:0] data);
      @(negedge clock);
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= user;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic issue_load(input logic start, input logic [pii_pkg::PIXEL_BITS-1:0] pixel);
      logic [pii_pkg::REQ_TDATA_W-1:0] data;
      // pad fields are don't-care on a load: fill them with noise
      data = {6'd0, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), pixel};
      send_request({start, pii_pkg::REQ_LOAD}, data);
      predict_table_load(pixel, start);
   endtask

   task automatic issue_read(input logic [pii_pkg::COORD_W-1:0] px,
                             input logic [pii_pkg::COORD_W-1:0] py,
                             input logic start, input logic typed,
                             input logic [pii_pkg::SUM_W-1:0] sum);
      logic [pii_pkg::REQ_TDATA_W-1:0] data;
      data = {6'd0, py, px, 8'($urandom_range(0, 255))};
      send_request({start, pii_pkg::REQ_READ}, data);
      if (typed) sum_expect_q.push_back(sum);
      else sum_expect_q.push_back(predict_padded_sum(px, py));
   endtask

   // Drop the request stream, drain all responses, then let the back end settle
   // on any trailing loads.
   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sum_expect_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input pii_pkg::reg_index_type sel,
                                 input logic [pii_pkg::CSR_DATA_W-1:0] value);
      wait_quiet();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (sel)
         pii_pkg::REG_IMG_WIDTH:  cfg_width  = value;
         pii_pkg::REG_IMG_HEIGHT: cfg_height = value;
         pii_pkg::REG_PAD_BORDER: cfg_pad    = value[pii_pkg::CFG_PAD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: random backpressure, one long hold-off on request.
   always begin
      @(negedge clock);
      if (hold_off_go && !hold_off_done) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_off_done = 1'b1;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Compare every accepted response against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sum_expect_q.size() == 0) begin
            $error("sum_value: expected none, actual %0d", rsp_tdata);
            mismatch_count++;
         end else begin
            if (rsp_tdata !== sum_expect_q[0]) begin
               $error("sum_value: expected %0d, actual %0d", sum_expect_q[0], rsp_tdata);
               mismatch_count++;
            end
            void'(sum_expect_q.pop_front());
         end
      end
   end

   // Watchdog: give up after too many cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      plan_row_type plan [PLAN_ROWS];
      logic [pii_pkg::COORD_W-1:0] rd_x, rd_y;
      logic [pii_pkg::CSR_DATA_W-1:0] w_data, h_data, p_data;
      int unsigned w, h, loads_left;
      int random_sent;
      int phase;

      // Small frame of full-scale pixels with a two-wide border: the table is
      // 255 510 765 / 510 1020 1530, so every read is easy to predict by hand.
      plan = '{
         '{STEP_CONFIG, pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd3,   9'd0,   1'b0, 24'd0},
         '{STEP_CONFIG, pii_pkg::REG_IMG_HEIGHT, 1'b0, 9'd2,   9'd0,   1'b0, 24'd0},
         '{STEP_CONFIG, pii_pkg::REG_PAD_BORDER, 1'b0, 9'd2,   9'd0,   1'b0, 24'd0},
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b1, 9'd255, 9'd0,   1'b0, 24'd0},
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd255, 9'd0,   1'b0, 24'd0},
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd255, 9'd0,   1'b0, 24'd0},
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd255, 9'd0,   1'b0, 24'd0},
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd255, 9'd0,   1'b0, 24'd0},
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd255, 9'd0,   1'b0, 24'd0},
         // top-left corner, top border, left border
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd0,   9'd0,   1'b1, 24'd0},
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd5,   9'd1,   1'b1, 24'd0},
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd1,   9'd300, 1'b1, 24'd0},
         // first image pixel; frame_start on a read is ignored
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b1, 9'd2,   9'd2,   1'b1, 24'd255},
         // far corner clamps to the last pixel
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd511, 9'd511, 1'b1, 24'd1530},
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd4,   9'd2,   1'b1, 24'd765},
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd511, 9'd2,   1'b1, 24'd765},
         // load after a full frame wraps to a new frame without frame_start
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd0,   9'd0,   1'b0, 24'd0},
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd2,   9'd2,   1'b1, 24'd0},
         // not yet reloaded in this frame: previous frame's value
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd3,   9'd3,   1'b0, 24'd0},
         // widest border (upper data bits dropped), zero width, oversize height
         '{STEP_CONFIG, pii_pkg::REG_PAD_BORDER, 1'b0, 9'h1FF, 9'd0,   1'b0, 24'd0},
         '{STEP_CONFIG, pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd0,   9'd0,   1'b0, 24'd0},
         '{STEP_CONFIG, pii_pkg::REG_IMG_HEIGHT, 1'b0, 9'd300, 9'd0,   1'b0, 24'd0},
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b1, 9'd170, 9'd0,   1'b0, 24'd0},
         '{STEP_LOAD,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd85,  9'd0,   1'b0, 24'd0},
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd127, 9'd127, 1'b1, 24'd170},
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd126, 9'd511, 1'b1, 24'd0},
         '{STEP_READ,   pii_pkg::REG_IMG_WIDTH,  1'b0, 9'd127, 9'd128, 1'b1, 24'd255}
      };

      // Hold reset, then release it at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         case (plan[i].kind)
            STEP_CONFIG: write_register(plan[i].reg_sel, plan[i].arg_a);
            STEP_LOAD:   issue_load(plan[i].start, plan[i].arg_a[pii_pkg::PIXEL_BITS-1:0]);
            default:     issue_read(plan[i].arg_a, plan[i].arg_b, plan[i].start,
                                    plan[i].has_sum, plan[i].sum);
         endcase
      end

      // Random phases: each sets new sizes, restarts the frame and loads it
      // (plus part of the next) in raster order with reads mixed in.
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase % 6)
            1: begin
               w_data = 9'($urandom_range(1, 12));
               h_data = 9'd0;
            end
            2: begin
               w_data = 9'($urandom_range(257, 511));   // behaves as the full width
               h_data = 9'($urandom_range(1, 2));
            end
            4: begin
               w_data = 9'($urandom_range(0, 1));
               h_data = 9'd256;
            end
            default: begin
               w_data = 9'($urandom_range(1, 12));
               h_data = 9'($urandom_range(1, 12));
            end
         endcase
         case ($urandom_range(0, 3))
            0:       p_data = 9'd0;
            1:       p_data = 9'd127;
            default: p_data = 9'($urandom_range(0, 127));
         endcase
         p_data[8:7] = 2'($urandom_range(0, 3));
         write_register(pii_pkg::REG_IMG_WIDTH, w_data);
         write_register(pii_pkg::REG_IMG_HEIGHT, h_data);
         write_register(pii_pkg::REG_PAD_BORDER, p_data);

         w = clip_dim(cfg_width, STORE_W);
         h = clip_dim(cfg_height, STORE_H);
         loads_left = w * h + $urandom_range(0, (w * h) / 4);

         // restart the frame so every row-above lookup hits loaded entries
         issue_load(1'b1, 8'($urandom_range(0, 255)));
         loads_left--;
         random_sent++;
         while (loads_left > 0 && random_sent < RANDOM_ITEMS) begin
            if (random_sent >= 300) hold_off_go = 1'b1;
            calm = (random_sent >= 800 && random_sent < 1000);
            if ($urandom_range(0, 99) < READ_PCT) begin
               pick_read_coords(rd_x, rd_y);
               issue_read(rd_x, rd_y, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
               // an occasional early restart breaks the raster sequence
               issue_load($urandom_range(0, 99) == 0, 8'($urandom_range(0, 255)));
               loads_left--;
            end
            random_sent++;
         end
         phase++;
      end

      calm = 1'b0;
      wait_quiet();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/pii_pkg.sv
src/pii_front.sv
src/pii_queue.sv
src/pii_back.sv
src/padded_integral_image_core.sv
src/pii_checker.sv
test/padded_integral_image_core_tb.sv
